// ----- rtl/irpwe_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// irpwe_pkg
// Shared types and constants of the IR pulse-width packet encoder.
// ----------------------------------------------------------------------------
package irpwe_pkg;

	localparam int PAYLOAD_W  = 24;
	localparam int TICKS_W    = 16;
	localparam int LONG_BITS  = 24;
	localparam int SHORT_BITS = 14;
	localparam int MAX_BITS   = (LONG_BITS > SHORT_BITS) ? LONG_BITS : SHORT_BITS;
	localparam int CNT_W      = $clog2(MAX_BITS + 1);
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);
	localparam int CFG_IDX_W  = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEADER = 3'd0,
		REG_ONE    = 3'd1,
		REG_ZERO   = 3'd2,
		REG_GAP    = 3'd3
	} reg_idx_t;

	localparam logic [TICKS_W-1:0] HEADER_RST = 16'd134;
	localparam logic [TICKS_W-1:0] ONE_RST    = 16'd67;
	localparam logic [TICKS_W-1:0] ZERO_RST   = 16'd34;
	localparam logic [TICKS_W-1:0] GAP_RST    = 16'd34;

	typedef struct packed {
		logic [TICKS_W-1:0] header_ticks;
		logic [TICKS_W-1:0] one_ticks;
		logic [TICKS_W-1:0] zero_ticks;
		logic [TICKS_W-1:0] gap_ticks;
	} timing_t;

	typedef struct packed {
		logic [PAYLOAD_W-1:0] payload;
		logic [CNT_W-1:0]     nbits;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage
`default_nettype wire

// ----- rtl/irpwe_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// irpwe_front
// Accepts packets, resolves the bit count and hands commands to the queue.
// ----------------------------------------------------------------------------
module irpwe_front (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            s_axis_tvalid,
	output logic                           s_axis_tready,
	input  wire [irpwe_pkg::PAYLOAD_W-1:0] s_axis_tdata,
	input  wire                            s_axis_tuser,
	input  irpwe_pkg::q_status_t           q_status,
	output logic                           q_push,
	output irpwe_pkg::cmd_t                q_cmd
);
	import irpwe_pkg::*;

	logic valid_s1;
	cmd_t cmd_s1;

	assign q_push        = valid_s1 && !q_status.full;
	assign q_cmd         = cmd_s1;
	assign s_axis_tready = !valid_s1 || !q_status.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1.payload <= s_axis_tdata;
			cmd_s1.nbits   <= s_axis_tuser ? CNT_W'(LONG_BITS) : CNT_W'(SHORT_BITS);
		end
	end

endmodule
`default_nettype wire

// ----- rtl/irpwe_cmd_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// irpwe_cmd_fifo
// Short command queue between the front and the segment sequencer.
// ----------------------------------------------------------------------------
module irpwe_cmd_fifo (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  irpwe_pkg::cmd_t      push_cmd,
	input  wire                  pop,
	output irpwe_pkg::cmd_t      head,
	output irpwe_pkg::q_status_t status
);
	import irpwe_pkg::*;

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign status.full  = (count_q == QCNT_W'(QDEPTH));
	assign status.empty = (count_q == '0);
	assign head         = mem_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)      count_q <= count_q + QCNT_W'(1);
			else if (pop && !push) count_q <= count_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_cmd;
	end

endmodule
`default_nettype wire

// ----- rtl/irpwe_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// irpwe_back
// Segment sequencer: walks one command into gap, header and bit segments.
// ----------------------------------------------------------------------------
module irpwe_back (
	input  wire                          clk,
	input  wire                          arst_n,
	input  irpwe_pkg::timing_t           timing,
	input  irpwe_pkg::cmd_t              head,
	input  irpwe_pkg::q_status_t         q_status,
	output logic                         pop,
	output logic                         m_axis_tvalid,
	input  wire                          m_axis_tready,
	output logic [irpwe_pkg::TICKS_W-1:0] m_axis_tdata,
	output logic                         m_axis_tuser,
	output logic                         m_axis_tlast
);
	import irpwe_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HEADER,
		ST_HDR_GAP,
		ST_MARK,
		ST_BIT_GAP
	} state_t;

	state_t               state_q;
	logic [PAYLOAD_W-1:0] shreg_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 advance;

	assign advance = !m_axis_tvalid || m_axis_tready;
	assign pop     = advance && (state_q == ST_IDLE) && !q_status.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			shreg_q       <= '0;
			cnt_q         <= '0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
			m_axis_tuser  <= 1'b0;
			m_axis_tlast  <= 1'b0;
		end else if (advance) begin
			unique case (state_q)
				ST_IDLE: begin
					m_axis_tvalid <= !q_status.empty;
					m_axis_tlast  <= 1'b0;
					m_axis_tuser  <= 1'b0;
					m_axis_tdata  <= timing.gap_ticks;
					shreg_q       <= head.payload;
					cnt_q         <= head.nbits;
					if (!q_status.empty) state_q <= ST_HEADER;
				end
				ST_HEADER: begin
					m_axis_tvalid <= 1'b1;
					m_axis_tlast  <= 1'b0;
					m_axis_tuser  <= 1'b1;
					m_axis_tdata  <= timing.header_ticks;
					state_q       <= ST_HDR_GAP;
				end
				ST_HDR_GAP: begin
					m_axis_tvalid <= 1'b1;
					m_axis_tlast  <= 1'b0;
					m_axis_tuser  <= 1'b0;
					m_axis_tdata  <= timing.gap_ticks;
					state_q       <= ST_MARK;
				end
				ST_MARK: begin
					m_axis_tvalid <= 1'b1;
					m_axis_tlast  <= 1'b0;
					m_axis_tuser  <= 1'b1;
					m_axis_tdata  <= shreg_q[PAYLOAD_W-1] ? timing.one_ticks
					                                      : timing.zero_ticks;
					shreg_q       <= shreg_q << 1;
					state_q       <= ST_BIT_GAP;
				end
				ST_BIT_GAP: begin
					m_axis_tvalid <= 1'b1;
					m_axis_tuser  <= 1'b0;
					m_axis_tdata  <= timing.gap_ticks;
					m_axis_tlast  <= (cnt_q == CNT_W'(1));
					cnt_q         <= cnt_q - CNT_W'(1);
					state_q       <= (cnt_q == CNT_W'(1)) ? ST_IDLE : ST_MARK;
				end
				default: begin
					state_q       <= ST_IDLE;
					m_axis_tvalid <= 1'b0;
					m_axis_tlast  <= 1'b0;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/ir_pulse_width_packet_encoder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ir_pulse_width_packet_encoder
// Turns IR packets into runs of timed line segments (pulse-width coding).
// ----------------------------------------------------------------------------
// Each packet (tdata = 24-bit payload, tuser = long packet) becomes a lead
// gap, a header mark, a gap, then per bit (MSB first) a mark of one or zero
// length and a gap; the final gap carries tlast. Output tuser is the line
// level, tdata the duration in ticks. The segment sequencer emits one
// segment per cycle while m_axis_tready does not stall it, with no bubble
// between packets; a two-entry command queue lets the input side take
// further packets meanwhile. Timing registers are written through the cfg
// port (index 0 header, 1 one, 2 zero, 3 gap; other indexes are ignored)
// and must only change while the block is idle.
// ----------------------------------------------------------------------------
module ir_pulse_width_packet_encoder (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire [irpwe_pkg::PAYLOAD_W-1:0]   s_axis_tdata,  // [23:0] payload
	input  wire                              s_axis_tuser,  // [0] long_packet
	output logic                             m_axis_tvalid,
	input  wire                              m_axis_tready,
	output logic [irpwe_pkg::TICKS_W-1:0]    m_axis_tdata,  // [15:0] duration
	output logic                             m_axis_tuser,  // [0] level
	output logic                             m_axis_tlast,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire [irpwe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire [irpwe_pkg::TICKS_W-1:0]     cfg_data
);
	import irpwe_pkg::*;

	timing_t   timing_q;
	q_status_t q_status;
	cmd_t      push_cmd;
	cmd_t      head;
	logic      q_push;
	logic      q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.header_ticks <= HEADER_RST;
			timing_q.one_ticks    <= ONE_RST;
			timing_q.zero_ticks   <= ZERO_RST;
			timing_q.gap_ticks    <= GAP_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_HEADER: timing_q.header_ticks <= cfg_data;
				REG_ONE:    timing_q.one_ticks    <= cfg_data;
				REG_ZERO:   timing_q.zero_ticks   <= cfg_data;
				REG_GAP:    timing_q.gap_ticks    <= cfg_data;
				default:    ;
			endcase
		end
	end

	irpwe_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_status      (q_status),
		.q_push        (q_push),
		.q_cmd         (push_cmd)
	);

	irpwe_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.head     (head),
		.status   (q_status)
	);

	irpwe_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.timing        (timing_q),
		.head          (head),
		.q_status      (q_status),
		.pop           (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_status.full && !q_pop))
		else $error("command pushed into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_status.empty))
		else $error("command popped from empty queue");

	a_last_is_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> !m_axis_tuser)
		else $error("final segment is not a gap");

	a_pop_starts_segment: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (m_axis_tvalid && !m_axis_tuser && !m_axis_tlast))
		else $error("packet start did not emit lead gap");

endmodule
`default_nettype wire

// ----- tb/sv/ir_pulse_width_packet_encoder_test.sv -----
// ----------------------------------------------------------------------------
// ir_pulse_width_packet_encoder_test
// Self-checking regression of the IR pulse-width packet encoder.
// ----------------------------------------------------------------------------
// Packets go in on the input stream while an internal predictor works out
// the line segments each packet should give. Every segment leaving the
// block is compared with the oldest predicted one. Directed packets cover
// default timing, timing extremes, zero durations and writes to unused
// register indexes; random phases then change the timing and send random
// packets with random idling on both streams, a long output hold-off and a
// closing stretch at full rate.
// ----------------------------------------------------------------------------
module ir_pulse_width_packet_encoder_test;
	timeunit 1ns;
	timeprecision 1ps;

	import irpwe_pkg::*;

	localparam int                   HOLD_CYCLES     = 300;
	localparam int                   WATCHDOG_LIMIT  = 2000;
	localparam int                   SETTLE_CYCLES   = 8;
	localparam int                   FINAL_CYCLES    = 60;
	localparam int                   MAX_REPORTS     = 10;
	localparam int                   CFG_IDX_LAST    = (1 << CFG_IDX_W) - 1;
	localparam logic [PAYLOAD_W-1:0] PAYLOAD_TOP_BIT = 24'h800000;

	typedef struct packed {
		logic               level;
		logic [TICKS_W-1:0] duration;
		logic               last;
	} segment_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 s_tvalid      = 1'b0;
	logic [PAYLOAD_W-1:0] s_tdata       = '0;
	logic                 s_tuser       = 1'b0;
	logic                 m_tready      = 1'b0;
	logic                 cfg_valid     = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [TICKS_W-1:0]   cfg_data      = '0;

	wire                  s_axis_tready;
	wire                  m_axis_tvalid;
	wire [TICKS_W-1:0]    m_axis_tdata;
	wire                  m_axis_tuser;
	wire                  m_axis_tlast;
	wire                  cfg_ready;

	timing_t              tick_regs;
	segment_t             segment_q[$];
	logic                 idle_en       = 1'b1;
	int                   hold_seq      = 0;
	int                   hold_seen     = 0;
	int                   hold_cnt      = 0;
	int                   stall_cnt     = 0;
	int                   quiet_cnt     = 0;
	int                   fail_cnt      = 0;
	int                   packets_sent  = 0;
	int                   segments_seen = 0;
	int                   writes_done   = 0;
	int                   input_stalls  = 0;

	ir_pulse_width_packet_encoder i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_tdata),       // [23:0] payload
		.s_axis_tuser  (s_tuser),       // [0] long_packet
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_axis_tdata),  // [15:0] duration
		.m_axis_tuser  (m_axis_tuser),  // [0] level
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void note_failure(input string what);
		fail_cnt++;
		if (fail_cnt <= MAX_REPORTS) begin
			$display("[%0t] mismatch: %s", $realtime, what);
		end
	endfunction

	function automatic void encode_packet(input logic [PAYLOAD_W-1:0] payload,
			input logic long_pkt);
		logic [PAYLOAD_W-1:0] shreg;
		int                   nbits;
		shreg = payload;
		nbits = long_pkt ? LONG_BITS : SHORT_BITS;
		segment_q.push_back('{level: 1'b0, duration: tick_regs.gap_ticks, last: 1'b0});
		segment_q.push_back('{level: 1'b1, duration: tick_regs.header_ticks, last: 1'b0});
		segment_q.push_back('{level: 1'b0, duration: tick_regs.gap_ticks, last: 1'b0});
		for (int i = 0; i < nbits; i++) begin
			segment_q.push_back('{level: 1'b1, last: 1'b0,
				duration: (shreg & PAYLOAD_TOP_BIT) != 0 ? tick_regs.one_ticks
					: tick_regs.zero_ticks});
			segment_q.push_back('{level: 1'b0, duration: tick_regs.gap_ticks, last: 1'b0});
			shreg = shreg << 1;
		end
		segment_q[$].last = 1'b1;
	endfunction

	function automatic logic [PAYLOAD_W-1:0] random_payload();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return PAYLOAD_TOP_BIT >> $urandom_range(0, PAYLOAD_W - 1);
			default: return PAYLOAD_W'($urandom);
		endcase
	endfunction

	function automatic logic [TICKS_W-1:0] random_ticks();
		case ($urandom_range(0, 3))
			0: return TICKS_W'($urandom_range(1, 16));
			1: return TICKS_W'($urandom_range(65520, 65535));
			default: return TICKS_W'($urandom_range(1, 65535));
		endcase
	endfunction

	// receiver: random stall bursts and the long hold-off
	always @(posedge clk) begin
		if (hold_cnt != 0) begin
			m_tready <= 1'b0;
			hold_cnt <= hold_cnt - 1;
		end else if (hold_seq != hold_seen) begin
			hold_seen <= hold_seq;
			hold_cnt  <= HOLD_CYCLES - 1;
			m_tready  <= 1'b0;
		end else if (stall_cnt != 0) begin
			m_tready  <= 1'b0;
			stall_cnt <= stall_cnt - 1;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			m_tready  <= 1'b0;
			stall_cnt <= $urandom_range(1, 6) - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		segment_t want;
		if (arst_n) begin
			if (s_tvalid && !s_axis_tready) begin
				input_stalls++;
			end
			if (m_axis_tvalid && m_tready) begin
				segments_seen++;
				if (segment_q.size() == 0) begin
					note_failure($sformatf("unexpected segment level %0b duration %0d last %0b",
						m_axis_tuser, m_axis_tdata, m_axis_tlast));
				end else begin
					want = segment_q.pop_front();
					if (m_axis_tuser !== want.level || m_axis_tdata !== want.duration ||
							m_axis_tlast !== want.last) begin
						note_failure($sformatf(
							"segment %0d expected level %0b duration %0d last %0b, got %0b %0d %0b",
							segments_seen, want.level, want.duration, want.last,
							m_axis_tuser, m_axis_tdata, m_axis_tlast));
					end
				end
			end
		end
	end

	// watchdog: end the run when no transaction moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready) ||
					(cfg_valid && cfg_ready)) begin
				quiet_cnt <= 0;
			end else if (quiet_cnt >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", quiet_cnt);
				$display("ir_pulse_width_packet_encoder regression: fail");
				$finish;
			end else begin
				quiet_cnt <= quiet_cnt + 1;
			end
		end
	end

	task automatic send_packet(input logic [PAYLOAD_W-1:0] payload, input logic long_pkt);
		s_tvalid <= 1'b1;
		s_tdata  <= payload;
		s_tuser  <= long_pkt;
		do @(posedge clk); while (!s_axis_tready);
		encode_packet(payload, long_pkt);
		packets_sent++;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// drop input valid and wait for every predicted segment
	task automatic drain();
		if (s_tvalid) begin
			s_tvalid <= 1'b0;
		end
		while (segment_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICKS_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_HEADER: tick_regs.header_ticks = value;
			REG_ONE:    tick_regs.one_ticks    = value;
			REG_ZERO:   tick_regs.zero_ticks   = value;
			REG_GAP:    tick_regs.gap_ticks    = value;
			default: ;
		endcase
		writes_done++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_timing(input logic [TICKS_W-1:0] header, input logic [TICKS_W-1:0] one,
			input logic [TICKS_W-1:0] zero, input logic [TICKS_W-1:0] gap);
		drain();
		write_reg(REG_HEADER, header);
		write_reg(REG_ONE, one);
		write_reg(REG_ZERO, zero);
		write_reg(REG_GAP, gap);
	endtask

	task automatic test_default_timing();
		send_packet(24'h000000, 1'b1);
		send_packet(24'hFFFFFF, 1'b1);
		send_packet(PAYLOAD_TOP_BIT, 1'b0);
		send_packet(24'h000001, 1'b1);
		send_packet(24'hAAAAAA, 1'b0);
		send_packet(24'h555555, 1'b1);
		send_packet(24'hFFFFFF, 1'b0);
		send_packet(24'h000000, 1'b0);
	endtask

	task automatic test_timing_extremes();
		write_timing(16'd1, 16'd1, 16'd1, 16'd1);
		send_packet(24'hA5A5A5, 1'b1);
		send_packet(24'h5A5A5A, 1'b0);
		write_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_packet(24'h0F0F0F, 1'b1);
		send_packet(24'hF0F0F0, 1'b0);
		write_timing(16'd7, 16'hFFFF, 16'd1, 16'd300);
		send_packet(24'hC3C3C3, 1'b1);
		// zero durations are passed through unchanged
		write_timing(16'd0, 16'd0, 16'd0, 16'd0);
		send_packet(24'h3C3C3C, 1'b1);
		send_packet(24'h123456, 1'b0);
	endtask

	task automatic test_unused_index();
		write_timing(HEADER_RST, ONE_RST, ZERO_RST, GAP_RST);
		for (int i = int'(REG_GAP) + 1; i <= CFG_IDX_LAST; i++) begin
			write_reg(CFG_IDX_W'(i), random_ticks());
		end
		send_packet(24'h9ABCDE, 1'b1);
	endtask

	task automatic test_random_phases(input int phases, input int per_phase);
		for (int p = 0; p < phases; p++) begin
			case (p)
				0: write_timing(16'd1, 16'hFFFF, 16'd1, 16'hFFFF);
				1: write_timing(16'hFFFF, 16'd1, 16'hFFFF, 16'd1);
				default: write_timing(random_ticks(), random_ticks(), random_ticks(),
					random_ticks());
			endcase
			for (int n = 0; n < per_phase; n++) begin
				send_packet(random_payload(), 1'($urandom));
			end
		end
	endtask

	// output held off while the input keeps offering, then pause for drain
	task automatic test_output_holdoff();
		drain();
		idle_en  <= 1'b0;
		hold_seq <= hold_seq + 1;
		for (int n = 0; n < 8; n++) begin
			send_packet(random_payload(), 1'($urandom));
		end
		drain();
		idle_en <= 1'b1;
		@(posedge clk);
	endtask

	task automatic test_full_rate(input int count);
		write_timing(random_ticks(), random_ticks(), random_ticks(), random_ticks());
		idle_en <= 1'b0;
		for (int n = 0; n < count; n++) begin
			send_packet(random_payload(), 1'($urandom));
		end
	endtask

	initial begin
		tick_regs = '{header_ticks: HEADER_RST, one_ticks: ONE_RST,
			zero_ticks: ZERO_RST, gap_ticks: GAP_RST};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_default_timing();
		test_timing_extremes();
		test_unused_index();
		test_random_phases(8, 50);
		test_output_holdoff();
		test_full_rate(60);

		drain();
		repeat (FINAL_CYCLES) @(posedge clk);
		if (segment_q.size() != 0) begin
			note_failure($sformatf("%0d segments never arrived", segment_q.size()));
		end
		$display("covered %0d packets, %0d segments, %0d register writes",
			packets_sent, segments_seen, writes_done);
		$display("input held back for %0d cycles, %0d mismatches", input_stalls, fail_cnt);
		if (fail_cnt == 0) begin
			$display("ir_pulse_width_packet_encoder regression: pass");
		end else begin
			$display("ir_pulse_width_packet_encoder regression: fail");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/irpwe_pkg.sv
rtl/irpwe_front.sv
rtl/irpwe_cmd_fifo.sv
rtl/irpwe_back.sv
rtl/ir_pulse_width_packet_encoder.sv
tb/sv/ir_pulse_width_packet_encoder_test.sv
